@@ hw/rtl/mvm_pkg.sv @@
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants for the fixed-point matrix-vector multiply core.
// ----------------------------------------------------------------------------
package mvm_pkg;

    // Field widths of the item formats
    localparam int VAL_W     = 16;   // Q8.8 element / weight
    localparam int PROD_W    = 32;   // Q16.16 product
    localparam int DOT_W     = 48;   // Q32.16 accumulator
    localparam int ROWIDX_W  = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    // Defaults for the top-level parameters
    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 1024;

    // Register reset value (before clamping)
    localparam int CFG_RESET = 1024;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b1;

    // Input item mode codes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_WEIGHT = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic signed [VAL_W-1:0]  value;
    } t_mvm_in;

    typedef struct packed {
        logic signed [DOT_W-1:0]  dot_product;
        logic [ROWIDX_W-1:0]      row_index;
        logic                     last_row;
    } t_mvm_out;

    // Per-weight control that travels down the MAC pipeline
    typedef struct packed {
        logic                 first;   // first column of a row: start from zero
        logic                 emit;    // last column: deliver the dot product
        logic                 last;    // final row of the pass
        logic [ROWIDX_W-1:0]  row;
    } t_mvm_tag;

endpackage

@@ hw/rtl/mvm_ram.sv @@
// ----------------------------------------------------------------------------
// mvm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/mvm_ctrl.sv @@
// ----------------------------------------------------------------------------
// mvm_ctrl
// Config registers, load/column/row counters and vector store addressing.
// ----------------------------------------------------------------------------
module mvm_ctrl #(
    parameter int MAX_COLS = mvm_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = mvm_pkg::MAX_ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config
    input  logic                              i_cfg_we,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mvm_pkg::CFG_W-1:0]         i_cfg_data,
    // input item
    input  logic                              i_in_valid,
    input  mvm_pkg::t_mvm_in                  i_in_item,
    input  logic                              i_adv,
    // vector store
    output logic                              o_ram_we,
    output logic [$clog2(MAX_COLS)-1:0]       o_ram_waddr,
    output logic [mvm_pkg::VAL_W-1:0]         o_ram_wdata,
    output logic                              o_ram_re,
    output logic [$clog2(MAX_COLS)-1:0]       o_ram_raddr,
    // stage 1 to MAC
    output logic                              o_s1_valid,
    output mvm_pkg::t_mvm_tag                 o_s1_tag,
    output logic signed [mvm_pkg::VAL_W-1:0]  o_s1_value
);
    import mvm_pkg::*;

    localparam int AW = $clog2(MAX_COLS);
    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int COLS_RST = (CFG_RESET > MAX_COLS) ? MAX_COLS : CFG_RESET;
    localparam int ROWS_RST = (CFG_RESET > MAX_ROWS) ? MAX_ROWS : CFG_RESET;

    // Clamped counts are kept, not the raw register values
    logic [CW-1:0] r_cols, n_cols_cfg;
    logic [RW-1:0] r_rows, n_rows_cfg;

    logic [CW-1:0] r_ld,  n_ld;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    logic          r_s1_valid;
    t_mvm_tag      r_s1_tag, n_s1_tag;
    logic signed [VAL_W-1:0] r_s1_value;

    logic          acc_load, acc_wgt;
    logic [CW-1:0] ld_idx, ld_nxt;
    logic [CW-1:0] col_a, col_nxt;
    logic [RW-1:0] row_a, row_b, row_nxt;
    logic          emit;

    assign acc_load = i_in_valid && i_adv && (i_in_item.mode == MODE_LOAD);
    assign acc_wgt  = i_in_valid && i_adv && (i_in_item.mode == MODE_WEIGHT);

    // Clamp counts to 1..MAX
    always_comb begin
        if (i_cfg_data == '0) begin
            n_cols_cfg = CW'(1);
        end else if (int'(i_cfg_data) > MAX_COLS) begin
            n_cols_cfg = CW'(MAX_COLS);
        end else begin
            n_cols_cfg = CW'(i_cfg_data);
        end
        if (i_cfg_data == '0) begin
            n_rows_cfg = RW'(1);
        end else if (int'(i_cfg_data) > MAX_ROWS) begin
            n_rows_cfg = RW'(MAX_ROWS);
        end else begin
            n_rows_cfg = RW'(i_cfg_data);
        end
    end

    // Vector load pointer
    always_comb begin
        ld_idx = (r_ld < r_cols) ? r_ld : '0;
        ld_nxt = ld_idx + CW'(1);
        n_ld   = (ld_nxt >= r_cols) ? '0 : ld_nxt;
    end

    // Column / row bookkeeping for one weight
    always_comb begin
        col_a = r_col;
        row_a = r_row;
        if (r_col >= r_cols) begin
            col_a = '0;
            row_a = r_row + RW'(1);
        end
        row_b   = (row_a >= r_rows) ? '0 : row_a;
        col_nxt = col_a + CW'(1);
        emit    = (col_nxt >= r_cols);
        row_nxt = row_b + RW'(1);

        n_col = emit ? '0 : col_nxt;
        n_row = emit ? ((row_nxt >= r_rows) ? '0 : row_nxt) : row_b;

        n_s1_tag.first = (col_a == '0);
        n_s1_tag.emit  = emit;
        n_s1_tag.last  = (row_nxt == r_rows);
        n_s1_tag.row   = ROWIDX_W'(row_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols     <= CW'(COLS_RST);
            r_rows     <= RW'(ROWS_RST);
            r_ld       <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_COLS: r_cols <= n_cols_cfg;
                    REG_ROWS: r_rows <= n_rows_cfg;
                    default: ;
                endcase
            end
            if (acc_load) begin
                r_ld <= n_ld;
            end
            if (acc_wgt) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_adv) begin
                r_s1_valid <= acc_wgt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_wgt) begin
            r_s1_tag   <= n_s1_tag;
            r_s1_value <= i_in_item.value;
        end
    end

    assign o_ram_we    = acc_load;
    assign o_ram_waddr = AW'(ld_idx);
    assign o_ram_wdata = i_in_item.value;
    assign o_ram_re    = acc_wgt;
    assign o_ram_raddr = AW'(col_a);

    assign o_s1_valid = r_s1_valid;
    assign o_s1_tag   = r_s1_tag;
    assign o_s1_value = r_s1_value;

    // Final row of a pass must wrap the row counter
    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_wgt && emit && n_s1_tag.last) |=> (r_row == '0))
        else $error("row counter did not wrap after final row");

    // One store access per item
    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ram_we && o_ram_re))
        else $error("vector store written and read by one item");

endmodule

@@ hw/rtl/mvm_mac.sv @@
// ----------------------------------------------------------------------------
// mvm_mac
// Product and accumulate stages with the result register.
// ----------------------------------------------------------------------------
module mvm_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s1_valid,
    input  mvm_pkg::t_mvm_tag                 i_s1_tag,
    input  logic signed [mvm_pkg::VAL_W-1:0]  i_s1_value,
    input  logic signed [mvm_pkg::VAL_W-1:0]  i_ram_rdata,
    input  logic                              i_out_stall,
    output logic                              o_adv,
    output logic                              o_out_valid,
    output mvm_pkg::t_mvm_out                 o_out_item
);
    import mvm_pkg::*;

    logic                     r_s2_valid;
    t_mvm_tag                 r_s2_tag;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DOT_W-1:0]  r_acc;
    logic signed [DOT_W-1:0]  acc_base, acc_sum;
    logic                     r_out_valid;
    t_mvm_out                 r_out;

    // Whole pipe moves unless a result sits stalled
    assign o_adv = !r_out_valid || !i_out_stall;

    // A row's first column starts from zero
    assign acc_base = r_s2_tag.first ? '0 : r_acc;
    assign acc_sum  = acc_base + DOT_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
        end else if (o_adv) begin
            r_s2_valid  <= i_s1_valid;
            r_out_valid <= r_s2_valid && r_s2_tag.emit;
            if (r_s2_valid) begin
                r_acc <= acc_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_s2_tag <= i_s1_tag;
            r_prod   <= PROD_W'(i_s1_value) * PROD_W'(i_ram_rdata);
            if (r_s2_valid && r_s2_tag.emit) begin
                r_out.dot_product <= acc_sum;
                r_out.row_index   <= r_s2_tag.row;
                r_out.last_row    <= r_s2_tag.last;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // A result appears only behind an emitting weight
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s2_valid && r_s2_tag.emit))
        else $error("result without a last-column weight");

    // Accumulator frozen while the pipe is held
    a_acc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_adv |=> $stable(r_acc))
        else $error("accumulator changed during stall");

endmodule

@@ hw/rtl/matrix_vector_multiply_core.sv @@
// An accepted last-column weight passes stage 1 and stage 2, then loads the result register and raises o_out_valid.
// Throughput: one item per cycle (loads and weights alike); one result per row.
// The only hold-off is a result stalled in the output register, which freezes the pipe.
// Reset (synchronous, i_rst_n low): counters and pipe valids clear, both count
// registers return to 1024 (clamped to the parameter maxima); vector store
// contents stay undefined until loaded.
// ----------------------------------------------------------------------------
// matrix_vector_multiply_core
// Fixed-point dense matrix-vector product: Q8.8 vector and weights, Q32.16 sums.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_core #(
    parameter int MAX_COLS = mvm_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = mvm_pkg::MAX_ROWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write port
    input  logic                           i_cfg_we,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mvm_pkg::CFG_W-1:0]      i_cfg_data,
    // input items
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  mvm_pkg::t_mvm_in               i_in_item,
    // result items
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output mvm_pkg::t_mvm_out              o_out_item
);
    import mvm_pkg::*;

    localparam int AW = $clog2(MAX_COLS);

    // Pipe:
    //   accept edge : counters update; a load writes the store, a weight
    //                 issues a store read at its column and registers stage 1
    //   stage 1     : store data back, 16x16 product registered
    //   stage 2     : accumulate; last column loads the result register
    // A load directly followed by a weight of the same column is safe: the
    // write lands at the load's accept edge, before the weight's read issues.

    logic                    adv;
    logic                    ram_we, ram_re;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [VAL_W-1:0]        ram_wdata, ram_rdata;
    logic                    s1_valid;
    t_mvm_tag                s1_tag;
    logic signed [VAL_W-1:0] s1_value;

    assign o_in_stall = !adv;

    mvm_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .i_adv       (adv),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_s1_valid  (s1_valid),
        .o_s1_tag    (s1_tag),
        .o_s1_value  (s1_value)
    );

    // Vector store, one entry per column
    mvm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_COLS)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mvm_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (s1_valid),
        .i_s1_tag    (s1_tag),
        .i_s1_value  (s1_value),
        .i_ram_rdata (signed'(ram_rdata)),
        .i_out_stall (i_out_stall),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

@@ dv/matrix_vector_multiply_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_vector_multiply_core_test
// Self-checking bench for the matrix-vector multiply core. A queue of load and
// weight items feeds a bursty driver. A bit-exact predictor runs on every
// accepted item, and a monitor checks each dot product against it under a
// random output stall pattern. Count registers are only changed while idle.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_core_test;

    import mvm_pkg::*;

    localparam int unsigned MAX_COLS     = MAX_COLS_DEF;
    localparam int unsigned MAX_ROWS     = MAX_ROWS_DEF;
    localparam int unsigned RANDOM_ITEMS = 650;
    localparam int unsigned PIPE_SETTLE  = 8;      // margin for the pipe to drain after the queues empty

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_mvm_in                i_in_item;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_mvm_out               o_out_item;

    matrix_vector_multiply_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    t_mvm_in                pending_items[$];
    t_mvm_out               expected_dots[$];
    t_mvm_out               want;
    bit                     in_fire;
    int unsigned            n_errors, n_loads, n_weights, n_dots, n_queued, n_settings;

    // Register mirrors (updated once a write has landed)
    logic [CFG_W-1:0]       reg_cols = CFG_W'(CFG_RESET);
    logic [CFG_W-1:0]       reg_rows = CFG_W'(CFG_RESET);

    // Predictor state, advanced on accepted items
    logic signed [VAL_W-1:0] vec_mem [0:MAX_COLS-1];
    int unsigned            ld_ptr, col_cnt, row_cnt;
    longint                 acc;

    // Generator shadow: keeps every weight pointed at a loaded vector entry
    bit                     gen_written [0:MAX_COLS-1];
    int unsigned            gen_ld_ptr, gen_col;

    // Sender and receiver pacing
    int unsigned            burst_left, gap_left, stall_left, stall_style;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int unsigned eff_count(input logic [CFG_W-1:0] r,
                                              input int unsigned maxv);
        if (r == 0) return 1;
        if (r > maxv) return maxv;
        return 32'(r);
    endfunction

    task automatic mac_predict(input t_mvm_in it);
        int unsigned cols, rows, idx;
        int          w, e;
        t_mvm_out    r;
        cols = eff_count(reg_cols, MAX_COLS);
        rows = eff_count(reg_rows, MAX_ROWS);
        if (it.mode == MODE_LOAD) begin
            // load pointer past the count (count lowered) lands on entry 0
            idx = (ld_ptr < cols) ? ld_ptr : 0;
            vec_mem[idx] = it.value;
            idx++;
            ld_ptr = (idx >= cols) ? 0 : idx;
            n_loads++;
        end else begin
            n_weights++;
            // counts lowered mid-row: start a fresh row / pass
            if (col_cnt >= cols) begin
                col_cnt = 0;
                acc     = 0;
                row_cnt++;
            end
            if (row_cnt >= rows) row_cnt = 0;
            w = int'(it.value);
            e = int'(vec_mem[col_cnt]);
            acc += longint'(w * e);
            col_cnt++;
            if (col_cnt >= cols) begin
                r.dot_product = acc[DOT_W-1:0];
                r.row_index   = ROWIDX_W'(row_cnt);
                r.last_row    = (row_cnt == rows - 1);
                expected_dots.push_back(r);
                acc     = 0;
                col_cnt = 0;
                row_cnt++;
                if (row_cnt >= rows) row_cnt = 0;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic signed [VAL_W-1:0] rand_q88();
        case ($urandom_range(0, 7))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return '0;
            3:       return -16'sd1;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    task automatic add_load(input logic signed [VAL_W-1:0] v);
        int unsigned cols, idx;
        t_mvm_in     it;
        cols = eff_count(reg_cols, MAX_COLS);
        idx  = (gen_ld_ptr < cols) ? gen_ld_ptr : 0;
        gen_written[idx] = 1'b1;
        idx++;
        gen_ld_ptr = (idx >= cols) ? 0 : idx;
        it.mode  = MODE_LOAD;
        it.value = v;
        pending_items.push_back(it);
        n_queued++;
    endtask

    // Loads are slipped in first if the target column was never written
    task automatic add_weight(input logic signed [VAL_W-1:0] v);
        int unsigned cols;
        t_mvm_in     it;
        cols = eff_count(reg_cols, MAX_COLS);
        if (gen_col >= cols) gen_col = 0;
        while (!gen_written[gen_col]) add_load(rand_q88());
        it.mode  = MODE_WEIGHT;
        it.value = v;
        pending_items.push_back(it);
        n_queued++;
        gen_col++;
        if (gen_col >= cols) gen_col = 0;
    endtask

    // Sender runs dry and every expected dot product comes back
    task automatic settle();
        while (pending_items.size() != 0 || i_in_valid || expected_dots.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_COLS) reg_cols = data;
        else reg_rows = data;
        n_settings++;
    endtask

    // One random setting: mostly a full vector then whole rows, with stray
    // loads, a possible mid-stream drain and a possible unfinished row.
    task automatic random_pass();
        int unsigned cols, rows, n_rows, sel, k;
        sel = $urandom_range(0, 19);
        if (sel < 14) cols = $urandom_range(1, 8);
        else if (sel < 19) cols = $urandom_range(9, 48);
        else cols = 0;
        sel = $urandom_range(0, 19);
        if (sel < 14) rows = $urandom_range(1, 6);
        else if (sel < 18) rows = $urandom_range(7, 40);
        else rows = 0;
        if ($urandom_range(0, 4) != 0) write_reg(REG_COLS, CFG_W'(cols));
        if ($urandom_range(0, 4) != 0) write_reg(REG_ROWS, CFG_W'(rows));
        cols = eff_count(reg_cols, MAX_COLS);
        rows = eff_count(reg_rows, MAX_ROWS);

        if ($urandom_range(0, 4) != 0) begin
            repeat (cols) add_load(rand_q88());
        end else begin
            repeat ($urandom_range(0, 3)) add_load(rand_q88());
        end

        n_rows = $urandom_range(1, (2 * rows + 1 < 12) ? 2 * rows + 1 : 12);
        for (k = 0; k < n_rows; k++) begin
            repeat (cols) begin
                if ($urandom_range(0, 19) == 0) add_load(rand_q88());
                add_weight(rand_q88());
            end
            if ($urandom_range(0, 29) == 0) settle();
        end
        if ($urandom_range(0, 2) == 0 && cols > 1)
            repeat ($urandom_range(1, cols - 1)) add_weight(rand_q88());
    endtask

    // ------------------------------------------------------------------------
    // Driver: pops items in bursts with random gaps; holds payload while stalled
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                i_in_valid <= 1'b1;
                i_in_item  <= pending_items.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: styles from never to mostly stalled, each held for a while
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(8, 60);
        end else begin
            stall_left--;
        end
        case (stall_style)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 2) == 0);
            2:       i_out_stall <= ($urandom_range(0, 7) != 0);
            default: i_out_stall <= 1'($urandom_range(0, 1));
        endcase
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on accepted inputs, check accepted results in order
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_fire = i_rst_n && i_in_valid && !o_in_stall;
        if (in_fire) mac_predict(i_in_item);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_dots.size() == 0) begin
                $error("dot_product: none expected, got %0d (row_index %0d)",
                       o_out_item.dot_product, o_out_item.row_index);
                n_errors++;
            end else begin
                want = expected_dots.pop_front();
                n_dots++;
                if (o_out_item.dot_product !== want.dot_product) begin
                    $error("dot_product: expected %0d, got %0d",
                           want.dot_product, o_out_item.dot_product);
                    n_errors++;
                end
                if (o_out_item.row_index !== want.row_index) begin
                    $error("row_index: expected %0d, got %0d",
                           want.row_index, o_out_item.row_index);
                    n_errors++;
                end
                if (o_out_item.last_row !== want.last_row) begin
                    $error("last_row: expected %0d, got %0d",
                           want.last_row, o_out_item.last_row);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned random_start, k, waited;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_COLS;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        for (k = 0; k < MAX_COLS; k++) begin
            gen_written[k] = 1'b0;
            vec_mem[k]     = '0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Three columns, two rows: extreme values, a pass wrap, a load mid-row
        write_reg(REG_COLS, 11'd3);
        write_reg(REG_ROWS, 11'd2);
        add_load(16'sd32767);
        add_load(-16'sd32768);
        add_load(-16'sd1);
        add_weight(-16'sd32768);
        add_weight(-16'sd32768);
        add_weight(16'sd32767);
        add_weight(16'sd32767);
        add_weight(16'sd1);
        add_weight(16'sd0);
        add_weight(-16'sd1);
        add_load(16'sd256);
        add_weight(16'sd256);
        add_weight(-16'sd32768);
        settle();

        // Zero counts clamp to one; load pointer above the count goes to entry 0
        write_reg(REG_COLS, 11'd0);
        write_reg(REG_ROWS, 11'd0);
        add_weight(16'sd2);
        add_load(16'sd5);
        add_weight(-16'sd3);
        settle();

        // Counts lowered in the middle of a row and of a pass
        write_reg(REG_COLS, 11'd4);
        write_reg(REG_ROWS, 11'd3);
        add_load(16'sd100);
        add_load(-16'sd200);
        add_load(16'sd300);
        add_weight(16'sd7);
        add_weight(-16'sd9);
        settle();
        write_reg(REG_COLS, 11'd2);
        add_load(16'sd11);
        add_weight(16'sd13);
        add_weight(-16'sd17);
        settle();
        write_reg(REG_ROWS, 11'd1);
        add_weight(16'sd19);
        add_weight(16'sd23);
        settle();

        // Wide row: 64 columns of the most negative value, sum past 32 bits
        write_reg(REG_COLS, 11'd64);
        write_reg(REG_ROWS, 11'd1024);
        repeat (64) add_load(-16'sd32768);
        repeat (64) add_weight(-16'sd32768);
        settle();

        // Full height: one column, rows clamped to 1024, one row past the wrap
        write_reg(REG_COLS, 11'd1);
        write_reg(REG_ROWS, 11'd2047);
        repeat (MAX_ROWS + 1) add_weight(rand_q88());
        settle();

        random_start = n_queued;
        while (n_queued - random_start < RANDOM_ITEMS) begin
            random_pass();
            settle();
        end

        waited = 0;
        while ((pending_items.size() != 0 || i_in_valid || expected_dots.size() != 0)
               && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (PIPE_SETTLE) @(posedge i_clk);
        if (expected_dots.size() != 0) begin
            $error("dot_product: %0d results never arrived", expected_dots.size());
            n_errors++;
        end

        $display("Summary: %0d items accepted (%0d loads, %0d weights), %0d dot products checked",
                 n_loads + n_weights, n_loads, n_weights, n_dots);
        $display("Summary: %0d register writes, clamped counts, a 64-wide row, a 1024-tall pass",
                 n_settings);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
